>>> design/wbrl_pkg.sv
// Shared types and constants for the weight/bias record loader.
package wbrl_pkg;

  localparam int WordW = 32;
  localparam int KindW = 2;
  localparam logic [WordW-1:0] MarkerValue = 32'h0000_0001;

  typedef enum logic [2:0] {
    PH_W_ADDR = 3'd0,
    PH_W_LEN  = 3'd1,
    PH_W_DATA = 3'd2,
    PH_B_ADDR = 3'd3,
    PH_B_LEN  = 3'd4,
    PH_B_DATA = 3'd5,
    PH_END    = 3'd6
  } phase_t;

  typedef enum logic [KindW-1:0] {
    KIND_NONE   = 2'd0,
    KIND_WORD   = 2'd1,
    KIND_MARKER = 2'd2
  } kind_t;

  typedef struct packed {
    phase_t           phase;
    logic [WordW-1:0] base_address;
    logic [WordW-1:0] words_written;
    logic [WordW-1:0] record_length;
  } state_t;

  typedef struct packed {
    kind_t            write_kind;
    logic [WordW-1:0] write_address;
    logic [WordW-1:0] write_data;
    logic             in_bias_section;
    logic             finished;
  } result_t;

endpackage

>>> design/wbrl_word_if.sv
// Input channel: one stream word per item.
interface wbrl_word_if import wbrl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

>>> design/wbrl_write_if.sv
// Output channel: one memory write request (or no-op) per item.
interface wbrl_write_if import wbrl_pkg::*; ();
  logic             valid;
  logic             ready;
  kind_t            write_kind;
  logic [WordW-1:0] write_address;
  logic [WordW-1:0] write_data;
  logic             in_bias_section;
  logic             finished;

  modport source (output valid, output write_kind, output write_address, output write_data,
                  output in_bias_section, output finished, input ready);
  modport sink   (input valid, input write_kind, input write_address, input write_data,
                  input in_bias_section, input finished, output ready);
endinterface

>>> design/wbrl_step.sv
// Record parser: next state and write request for one stream word.
module wbrl_step import wbrl_pkg::*; (
  input  state_t           st,
  input  logic [WordW-1:0] word,
  output state_t           st_next,
  output result_t          res
);

  logic [WordW-1:0] count_inc;
  logic             last_word;
  logic [WordW-1:0] payload_addr;

  assign count_inc    = st.words_written + WordW'(1);
  assign last_word    = (count_inc == st.record_length);
  assign payload_addr = st.base_address + {st.words_written[WordW-3:0], 2'b00};

  // Next state
  always_comb begin
    st_next = st;
    unique case (st.phase)
      PH_W_ADDR: begin
        st_next.base_address = word;
        st_next.phase        = (word == '0) ? PH_B_ADDR : PH_W_LEN;
      end
      PH_W_LEN, PH_B_LEN: begin
        st_next.record_length = word;
        st_next.words_written = '0;
        st_next.phase         = (st.phase == PH_W_LEN) ? PH_W_DATA : PH_B_DATA;
      end
      PH_W_DATA: begin
        st_next.words_written = count_inc;
        if (last_word) st_next.phase = PH_W_ADDR;
      end
      PH_B_ADDR: begin
        st_next.base_address = word;
        st_next.phase        = (word == '0) ? PH_END : PH_B_LEN;
      end
      PH_B_DATA: begin
        st_next.words_written = count_inc;
        if (last_word) st_next.phase = PH_B_ADDR;
      end
      default: ;  // finished or unused code: ignore input
    endcase
  end

  // Write request
  always_comb begin
    res.write_kind    = KIND_NONE;
    res.write_address = '0;
    res.write_data    = '0;
    unique case (st.phase)
      PH_W_ADDR: begin
        if (word != '0) begin
          res.write_kind    = KIND_MARKER;
          res.write_address = word | WordW'(1);
          res.write_data    = MarkerValue;
        end
      end
      PH_W_DATA, PH_B_DATA: begin
        res.write_kind    = KIND_WORD;
        res.write_address = payload_addr;
        res.write_data    = word;
      end
      default: ;
    endcase
    res.in_bias_section = (st_next.phase >= PH_B_ADDR) || (st.phase > PH_END);
    res.finished        = (st_next.phase >= PH_END);
  end

endmodule

>>> design/wbrl_out_reg.sv
// Result register: holds one write request until the sink takes it.
module wbrl_out_reg import wbrl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t d,
  input  logic    take,
  output logic    can_load,
  output logic    valid,
  output result_t q
);

  assign can_load = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

>>> design/weight_bias_record_loader.sv
// Top level of the weight/bias record loader.
//
// Turns a stream of 32-bit words into memory write requests. The stream is a
// weight section followed by a bias section; each record is a base address, a
// word count and that many payload words. A zero address closes the weight
// section, a second zero address closes the bias section, after which every
// word yields a no-op result. A nonzero weight address first yields a marker
// byte write of 1 at (address | 1); payload word k goes to base + 4k. A count
// of zero wraps, so such a record runs for 2^32 payload words. Each word gives
// exactly one result item, kind NONE meaning no write (address and data 0).
// Throughput is one item per clock while the sink keeps up: the parser state
// and the single output register both load on the edge that accepts the word.
// The input is ready whenever that register is empty or being drained, so a
// stalled sink holds one result and back-pressures the stream.
module weight_bias_record_loader import wbrl_pkg::*; (
  input logic         clk,
  input logic         rst,
  wbrl_word_if.sink   words,
  wbrl_write_if.source writes
);

  state_t  st;
  state_t  st_next;
  result_t res;
  result_t res_q;
  logic    can_load;
  logic    accept;
  logic    out_valid;

  wbrl_step u_step (
    .st      (st),
    .word    (words.word),
    .st_next (st_next),
    .res     (res)
  );

  assign words.ready = can_load;
  assign accept      = words.valid && can_load;

  // parser state advances only on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= PH_W_ADDR;
      st.base_address  <= '0;
      st.words_written <= '0;
      st.record_length <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  wbrl_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .d        (res),
    .take     (writes.ready),
    .can_load (can_load),
    .valid    (out_valid),
    .q        (res_q)
  );

  assign writes.valid           = out_valid;
  assign writes.write_kind      = res_q.write_kind;
  assign writes.write_address   = res_q.write_address;
  assign writes.write_data      = res_q.write_data;
  assign writes.in_bias_section = res_q.in_bias_section;
  assign writes.finished        = res_q.finished;

  // an accepted item always shows up in the result register next cycle
  a_accept_to_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  // finished implies the bias section flag
  a_finished_in_bias: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_q.finished) |-> res_q.in_bias_section)
    else $error("finished without bias section");

  // marker writes only in the weight section, at an odd address
  a_marker_weight_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_q.write_kind == KIND_MARKER) |->
      (!res_q.in_bias_section && res_q.write_address[0]))
    else $error("bad marker write");

  // once finished, the parser stays finished
  a_end_sticky: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_END) |=> (st.phase == PH_END))
    else $error("left the end phase");

endmodule

>>> tb/tb_weight_bias_record_loader.sv
// Self-checking testbench for the weight/bias record loader: directed and random record streams.
module tb_weight_bias_record_loader;
  import wbrl_pkg::*;

  // Cycles without any item accepted on either channel before the run is abandoned.
  // The longest legal quiet stretch is a sender gap plus a sink stall.
  localparam int IdleLimit = 400;

  logic clk = 1'b0;
  logic rst;

  wbrl_word_if  word_ch ();
  wbrl_write_if write_ch ();

  weight_bias_record_loader dut (
    .clk    (clk),
    .rst    (rst),
    .words  (word_ch),
    .writes (write_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: a private copy of the parser registers.
  phase_t      parse_phase = PH_W_ADDR;
  logic [31:0] record_base = '0;
  logic [31:0] record_count = '0;
  logic [31:0] record_words = '0;

  // Writes the loader must still produce, oldest first.
  result_t expected_writes[$];

  int unsigned sent_count = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  // Percent chance of an idle burst before each item (sender) or cycle (sink).
  int unsigned src_gap_pct = 0;
  int unsigned snk_stall_pct = 0;

  // Advance the parser by one stream word and return the write it causes.
  function result_t parse_word(input logic [31:0] w);
    result_t r;
    r = '0;
    r.write_kind = KIND_NONE;
    case (parse_phase)
      PH_W_ADDR: begin
        record_base = w;
        if (w == '0) begin
          parse_phase = PH_B_ADDR;
        end else begin
          // nonzero weight address: marker byte at the odd address
          r.write_kind    = KIND_MARKER;
          r.write_address = w | 32'd1;
          r.write_data    = MarkerValue;
          parse_phase     = PH_W_LEN;
        end
      end
      PH_W_LEN, PH_B_LEN: begin
        record_words = w;
        record_count = '0;
        parse_phase  = (parse_phase == PH_W_LEN) ? PH_W_DATA : PH_B_DATA;
      end
      PH_W_DATA, PH_B_DATA: begin
        r.write_kind    = KIND_WORD;
        r.write_address = record_base + (record_count << 2);
        r.write_data    = w;
        // count bumps before the compare, so a zero length wraps around
        record_count    = record_count + 32'd1;
        if (record_count == record_words)
          parse_phase = (parse_phase == PH_W_DATA) ? PH_W_ADDR : PH_B_ADDR;
      end
      PH_B_ADDR: begin
        // bias address is stored but never marked
        record_base = w;
        parse_phase = (w == '0) ? PH_END : PH_B_LEN;
      end
      default: ;  // finished: word is dropped
    endcase
    r.in_bias_section = (parse_phase >= PH_B_ADDR);
    r.finished        = (parse_phase >= PH_END);
    return r;
  endfunction

  // Random word, biased toward the corners now and then.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_address();
    logic [31:0] a;
    a = rand_word();
    while (a == '0) a = rand_word();
    return a;
  endfunction

  // Drive one item, wait for the handshake, then record the expected write.
  // Valid stays high between back-to-back items; only a gap lowers it.
  task automatic send_word(input logic [31:0] w);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      word_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    word_ch.valid <= 1'b1;
    word_ch.word  <= w;
    @(posedge clk);
    while (!word_ch.ready) @(posedge clk);
    expected_writes.push_back(parse_word(w));
    sent_count++;
  endtask

  // Address, length, then random payload; short records are the common case.
  task automatic send_record(input logic [31:0] addr);
    int unsigned len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 48) : $urandom_range(1, 6);
    send_word(addr);
    send_word(len);
    repeat (len) send_word(rand_word());
  endtask

  // Corners of the weight section: wrap of the base, even/odd marker address,
  // single-word record, all-zero and all-one payloads.
  task automatic test_weight_extremes();
    src_gap_pct   = 20;
    snk_stall_pct = 20;
    send_word(32'hFFFF_FFFF);    // marker stays at the top address
    send_word(32'd3);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);    // base + 4 wraps to 3
    send_word(32'h1234_5678);
    send_word(32'h0000_0002);    // even address: marker at 3
    send_word(32'd1);
    send_word(32'hFFFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'd2);
    send_word(32'hAAAA_AAAA);
    send_word(32'h5555_5555);
  endtask

  // Bulk of the weight section with shifting idle pressure, including a quiet stretch.
  task automatic test_weight_records();
    while (sent_count < 600) begin
      if (sent_count < 250) begin
        src_gap_pct   = 25;
        snk_stall_pct = 15;
      end else if (sent_count < 350) begin
        src_gap_pct   = 0;
        snk_stall_pct = 0;
      end else begin
        src_gap_pct   = 10;
        snk_stall_pct = 40;
      end
      send_record(rand_address());
    end
  endtask

  task automatic test_weight_close();
    send_word(32'h0000_0000);
  endtask

  // Bias records near the wrap and at an odd address; neither may emit a marker.
  task automatic test_bias_extremes();
    src_gap_pct   = 30;
    snk_stall_pct = 30;
    send_word(32'hFFFF_FFFC);
    send_word(32'd2);
    send_word(32'h0F0F_0F0F);
    send_word(32'hF0F0_F0F0);
    send_word(32'h0000_0001);
    send_word(32'd1);
    send_word(32'hFFFF_FFFF);
  endtask

  // Random bias records; the tail of the run goes without any idling.
  task automatic test_bias_records();
    while (sent_count < 1150) begin
      if (sent_count < 900) begin
        src_gap_pct   = 25;
        snk_stall_pct = 25;
      end else begin
        src_gap_pct   = 0;
        snk_stall_pct = 0;
      end
      send_record(rand_address());
    end
  endtask

  // Usually the terminator and a run of ignored words. A zero-length record can
  // never close within the run, so it only ends some runs, picked by the seed.
  task automatic test_stream_close();
    if ($urandom_range(0, 3) != 0) begin
      send_word(32'h0000_0000);
      repeat (30) send_word(rand_word());
    end else begin
      send_word(rand_address());
      send_word(32'h0000_0000);
      repeat (40) send_word(rand_word());
    end
  endtask

  task automatic drain();
    word_ch.valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    // result register is one stage deep; a few more cycles catch strays
    repeat (8) @(posedge clk);
  endtask

  // Sink side: random stall bursts, ready otherwise.
  initial begin
    write_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct) begin
        write_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      write_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic field_check(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted write with the oldest expectation.
  always @(posedge clk) begin : write_check
    result_t want;
    if (!rst && write_ch.valid && write_ch.ready) begin
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected write, expected none, actual kind %0d addr %h data %h",
                 $realtime, write_ch.write_kind, write_ch.write_address,
                 write_ch.write_data);
        mismatches++;
      end else begin
        want = expected_writes.pop_front();
        field_check("write_kind", 32'(want.write_kind), 32'(write_ch.write_kind));
        field_check("write_address", want.write_address, write_ch.write_address);
        field_check("write_data", want.write_data, write_ch.write_data);
        field_check("in_bias_section", 32'(want.in_bias_section),
                    32'(write_ch.in_bias_section));
        field_check("finished", 32'(want.finished), 32'(write_ch.finished));
      end
    end
  end

  // Watchdog: any accepted item on either side resets the count.
  always @(posedge clk) begin
    if (rst || (word_ch.valid && word_ch.ready) || (write_ch.valid && write_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("%0t: no item accepted for %0d cycles", $realtime, IdleLimit);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst           <= 1'b1;
    word_ch.valid <= 1'b0;
    word_ch.word  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_weight_extremes();
    test_weight_records();
    test_weight_close();
    test_bias_extremes();
    test_bias_records();
    test_stream_close();
    drain();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
